>>> rtl/mibe_pkg.sv
package mibe_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned IMM_W     = 26;
  localparam int unsigned REG_IDX_W = 5;

  localparam logic [REG_IDX_W-1:0] LINK_REG   = 5'd31;
  localparam logic [31:0]          INSN_BYTES = 32'd4;

  // Upper pc bits that a jump keeps (region select)
  localparam int unsigned JUMP_KEEP_W = XLEN - IMM_W - 2;

  localparam int unsigned IN_TDATA_W  = 224;
  localparam int unsigned IN_TUSER_W  = 5;
  localparam int unsigned OUT_TDATA_W = 144;

  typedef enum logic [4:0] {
    OP_ADDI   = 5'd0,
    OP_ADDIU  = 5'd1,
    OP_ANDI   = 5'd2,
    OP_BEQ    = 5'd3,
    OP_BEQL   = 5'd4,
    OP_BLEZ   = 5'd5,
    OP_BLEZL  = 5'd6,
    OP_BNE    = 5'd7,
    OP_BNEL   = 5'd8,
    OP_BGTZ   = 5'd9,
    OP_BGTZL  = 5'd10,
    OP_DADDI  = 5'd11,
    OP_DADDIU = 5'd12,
    OP_J      = 5'd13,
    OP_JAL    = 5'd14,
    OP_LUI    = 5'd15,
    OP_ORI    = 5'd16,
    OP_SLTI   = 5'd17,
    OP_SLTIU  = 5'd18,
    OP_XORI   = 5'd19
  } opcode_t;

  typedef struct packed {
    opcode_t               opcode;
    logic [XLEN-1:0]       rs_value;
    logic [XLEN-1:0]       rt_value;
    logic [IMM_W-1:0]      immediate;
    logic [REG_IDX_W-1:0]  target_reg;
    logic [XLEN-1:0]       pc;
  } item_t;

  typedef struct packed {
    logic                  write_enable;
    logic [REG_IDX_W-1:0]  write_index;
    logic [XLEN-1:0]       write_value;
    logic                  redirect;
    logic [XLEN-1:0]       redirect_target;
    logic                  skip_delay_slot;
    logic                  overflow_fault;
  } result_t;

endpackage

>>> rtl/mibe_exec.sv
module mibe_exec (
  input  mibe_pkg::item_t   item,
  output mibe_pkg::result_t res
);

  logic [mibe_pkg::XLEN-1:0] simm;
  logic [mibe_pkg::XLEN-1:0] zimm;
  logic [mibe_pkg::XLEN-1:0] sum;
  logic [mibe_pkg::XLEN-1:0] btarget;
  logic [mibe_pkg::XLEN-1:0] jtarget;
  logic [31:0]               link32;
  logic                      ovf32;
  logic                      ovf64;
  logic                      rs_zero;
  logic                      rs_neg;
  logic                      is_branch;
  logic                      likely;
  logic                      cond;

  assign simm = {{(mibe_pkg::XLEN-16){item.immediate[15]}}, item.immediate[15:0]};
  assign zimm = {{(mibe_pkg::XLEN-16){1'b0}}, item.immediate[15:0]};

  // One adder serves both word and doubleword adds: the low half is the word sum
  assign sum   = item.rs_value + simm;
  assign ovf32 = (item.rs_value[31] ^ sum[31]) & (simm[31] ^ sum[31]);
  assign ovf64 = (item.rs_value[63] ^ sum[63]) & (simm[63] ^ sum[63]);

  assign btarget = item.pc + {simm[mibe_pkg::XLEN-3:0], 2'b00};
  assign jtarget = {item.pc[mibe_pkg::XLEN-1 -: mibe_pkg::JUMP_KEEP_W], item.immediate, 2'b00};
  assign link32  = item.pc[31:0] + mibe_pkg::INSN_BYTES;

  assign rs_zero = (item.rs_value == '0);
  assign rs_neg  = item.rs_value[mibe_pkg::XLEN-1];

  always_comb begin
    res       = '0;
    is_branch = 1'b0;
    likely    = 1'b0;
    cond      = 1'b0;
    case (item.opcode)
      mibe_pkg::OP_ADDI, mibe_pkg::OP_ADDIU: begin
        if (item.opcode == mibe_pkg::OP_ADDI && ovf32) begin
          res.overflow_fault = 1'b1;
        end else begin
          res.write_enable = 1'b1;
          res.write_value  = {{32{sum[31]}}, sum[31:0]};
        end
      end
      mibe_pkg::OP_DADDI, mibe_pkg::OP_DADDIU: begin
        if (item.opcode == mibe_pkg::OP_DADDI && ovf64) begin
          res.overflow_fault = 1'b1;
        end else begin
          res.write_enable = 1'b1;
          res.write_value  = sum;
        end
      end
      mibe_pkg::OP_ANDI: begin
        res.write_enable = 1'b1;
        res.write_value  = item.rs_value & zimm;
      end
      mibe_pkg::OP_ORI: begin
        res.write_enable = 1'b1;
        res.write_value  = item.rs_value | zimm;
      end
      mibe_pkg::OP_XORI: begin
        res.write_enable = 1'b1;
        res.write_value  = item.rs_value ^ zimm;
      end
      mibe_pkg::OP_LUI: begin
        res.write_enable = 1'b1;
        res.write_value  = {{32{item.immediate[15]}}, item.immediate[15:0], 16'h0000};
      end
      mibe_pkg::OP_SLTI: begin
        res.write_enable = 1'b1;
        res.write_value  = {{(mibe_pkg::XLEN-1){1'b0}},
                            ($signed(item.rs_value) < $signed(simm))};
      end
      mibe_pkg::OP_SLTIU: begin
        res.write_enable = 1'b1;
        res.write_value  = {{(mibe_pkg::XLEN-1){1'b0}}, (item.rs_value < simm)};
      end
      mibe_pkg::OP_BEQ, mibe_pkg::OP_BEQL: begin
        is_branch = 1'b1;
        likely    = (item.opcode == mibe_pkg::OP_BEQL);
        cond      = (item.rs_value == item.rt_value);
      end
      mibe_pkg::OP_BNE, mibe_pkg::OP_BNEL: begin
        is_branch = 1'b1;
        likely    = (item.opcode == mibe_pkg::OP_BNEL);
        cond      = (item.rs_value != item.rt_value);
      end
      mibe_pkg::OP_BLEZ, mibe_pkg::OP_BLEZL: begin
        is_branch = 1'b1;
        likely    = (item.opcode == mibe_pkg::OP_BLEZL);
        cond      = rs_zero | rs_neg;
      end
      mibe_pkg::OP_BGTZ, mibe_pkg::OP_BGTZL: begin
        is_branch = 1'b1;
        likely    = (item.opcode == mibe_pkg::OP_BGTZL);
        cond      = ~rs_zero & ~rs_neg;
      end
      mibe_pkg::OP_J: begin
        res.redirect        = 1'b1;
        res.redirect_target = jtarget;
      end
      mibe_pkg::OP_JAL: begin
        res.redirect        = 1'b1;
        res.redirect_target = jtarget;
        res.write_enable    = 1'b1;
        res.write_value     = {{32{link32[31]}}, link32};
      end
      default: begin
      end
    endcase

    if (is_branch) begin
      if (cond) begin
        res.redirect        = 1'b1;
        res.redirect_target = btarget;
      end else begin
        res.skip_delay_slot = likely;
      end
    end

    // Index only reported with a write; JAL links to the return register
    if (res.write_enable) begin
      res.write_index = (item.opcode == mibe_pkg::OP_JAL) ? mibe_pkg::LINK_REG
                                                          : item.target_reg;
    end
  end

endmodule

>>> rtl/mips_immediate_and_branch_execute.sv
// An input transfer is held in the input register, then its result in the result
// register after the execute logic. Throughput: one instruction per cycle when the
// output does not stall; each stage advances whenever the stage after it is empty
// or being drained, so out_tready stalls back to in_tready.
// Reset: rst_n low at a clock edge empties both stages; payload is not cleared.
module mips_immediate_and_branch_execute (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // rs_value[63:0], rt_value[127:64], immediate[153:128], target_reg[158:154],
  // pc[222:159], zero pad[223]
  input  logic [mibe_pkg::IN_TDATA_W-1:0]     in_tdata,
  // opcode[4:0]
  input  logic [mibe_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // write_enable[0], write_index[5:1], write_value[69:6], redirect[70],
  // redirect_target[134:71], skip_delay_slot[135], overflow_fault[136], zero pad[143:137]
  output logic [mibe_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  mibe_pkg::item_t   s1_item_r;
  mibe_pkg::item_t   s1_item_nxt;
  logic              s2_valid_r;
  logic              s2_valid_nxt;
  mibe_pkg::result_t s2_res_r;
  mibe_pkg::result_t exec_res;
  logic              s2_free;
  logic              s1_free;
  logic              in_xfer;

  assign s2_free   = ~s2_valid_r | out_tready;
  assign s1_free   = ~s1_valid_r | s2_free;
  assign in_tready = s1_free;
  assign in_xfer   = in_tvalid & in_tready;

  always_comb begin
    s1_item_nxt.opcode     = mibe_pkg::opcode_t'(in_tuser[4:0]);
    s1_item_nxt.rs_value   = in_tdata[63:0];
    s1_item_nxt.rt_value   = in_tdata[127:64];
    s1_item_nxt.immediate  = in_tdata[153:128];
    s1_item_nxt.target_reg = in_tdata[158:154];
    s1_item_nxt.pc         = in_tdata[222:159];
  end

  assign s1_valid_nxt = s1_free ? in_tvalid : s1_valid_r;
  assign s2_valid_nxt = s2_free ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= s1_item_nxt;
    end
    if (s2_free && s1_valid_r) begin
      s2_res_r <= exec_res;
    end
  end

  mibe_exec u_exec (
    .item (s1_item_r),
    .res  (exec_res)
  );

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {7'b0,
                       s2_res_r.overflow_fault,
                       s2_res_r.skip_delay_slot,
                       s2_res_r.redirect_target,
                       s2_res_r.redirect,
                       s2_res_r.write_value,
                       s2_res_r.write_index,
                       s2_res_r.write_enable};

`ifndef SYNTHESIS
  a_ovf_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_res_r.overflow_fault |-> !s2_res_r.write_enable)
    else $error("overflow fault with register write");

  a_redirect_xor_skip: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> !(s2_res_r.redirect && s2_res_r.skip_delay_slot))
    else $error("redirect and delay-slot annul together");

  a_jal_link: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_item_r.opcode == mibe_pkg::OP_JAL |->
      exec_res.write_index == mibe_pkg::LINK_REG && exec_res.redirect)
    else $error("JAL did not link to return register");

  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid_r)
    else $error("accepted transfer lost in input stage");

  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_free |=> s2_valid_r)
    else $error("executed item lost before result stage");
`endif

endmodule
